>>> hw/rtl/vgc_pkg.sv
// ============================================================================
// vgc_pkg
// Shared types and constants of the voltage-gated channel update core.
// ============================================================================
package vgc_pkg;

    // fixed-point format and range limits
    localparam int FRAC_BITS = 16;
    localparam int EXP_LIMIT = 48;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // exp constants, Q30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // unit latencies in cycles
    localparam int LAT_EXP   = 19;
    localparam int DIV_NUM_W = 63;
    localparam int DIV_DEN_W = 33;
    localparam int LAT_DIV   = DIV_NUM_W;

    // pipeline stage indexes (stage k is computed from stage k-1)
    localparam int S_EXP_IN  = 3;
    localparam int S_EXP_OUT = S_EXP_IN + LAT_EXP;
    localparam int S_SUM     = S_EXP_OUT + 1;
    localparam int S_PROD    = S_SUM + 1;
    localparam int S_DIV_OUT = S_PROD + LAT_DIV;
    localparam int S_R       = S_DIV_OUT + 1;
    localparam int S_DP      = S_R + 1;
    localparam int S_M       = S_DP + 1;
    localparam int S_GM      = S_M + 1;
    localparam int S_PC      = S_GM + 1;
    localparam int NSTG      = S_PC + 1;

    typedef struct packed {
        logic               mode;
        logic [9:0]         channel;
        logic signed [31:0] membrane_v;
        logic [15:0]        neuron_id;
        logic signed [31:0] half_voltage;
        logic signed [31:0] opening_scale;
        logic signed [31:0] closing_scale;
        logic signed [31:0] steady_scale;
        logic [30:0]        tau_factor;
        logic [30:0]        max_conductance;
        logic signed [31:0] reversal_voltage;
        logic [16:0]        gate_initial;
    } t_in_beat;

    typedef struct packed {
        logic [9:0]         channel_out;
        logic [15:0]        neuron_out;
        logic [16:0]        gate_value;
        logic signed [31:0] current_out;
    } t_out_beat;

    // channel table entry (gate held apart)
    typedef struct packed {
        logic [15:0]        neuron;
        logic signed [31:0] half;
        logic signed [31:0] sc_open;
        logic signed [31:0] sc_close;
        logic signed [31:0] sc_steady;
        logic [30:0]        tau;
        logic [30:0]        cond;
        logic signed [31:0] erev;
    } t_prm;

    // per-item data that travels alongside the datapath
    typedef struct packed {
        logic               mode;
        logic [9:0]         ch;
        logic [15:0]        neuron;
        logic signed [31:0] v;
        logic [16:0]        gate;
        logic [30:0]        tau;
        logic [30:0]        cond;
        logic signed [31:0] erev;
    } t_side;

endpackage

>>> hw/rtl/vgc_in_if.sv
// ============================================================================
// vgc_in_if
// Input beat channel: valid/ready handshake with the item payload.
// ============================================================================
interface vgc_in_if;
    logic               valid;
    logic               ready;
    vgc_pkg::t_in_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vgc_out_if.sv
// ============================================================================
// vgc_out_if
// Result beat channel: valid/ready handshake with the result payload.
// ============================================================================
interface vgc_out_if;
    logic               valid;
    logic               ready;
    vgc_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vgc_exp.sv
// ============================================================================
// vgc_exp
// Pipelined fixed-point exp: 2^(x*log2e) split into integer shift and a
// degree-eight Taylor series of the fraction in multiply and divide stages.
// ============================================================================
module vgc_exp (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [22:0] i_arg,
    output logic [31:0]        o_val
);

    localparam int NT = 17;

    logic signed [54:0] y_full;
    logic [59:0]        z_full;
    logic signed [23:0] r_y;
    logic [30:0]        r_t  [NT];
    logic [31:0]        r_s  [NT];
    logic [29:0]        r_z  [NT];
    logic signed [7:0]  r_n  [NT];
    logic [31:0]        r_val;
    logic signed [8:0]  sh;
    logic [8:0]         nsh;
    logic [63:0]        wide;
    logic [31:0]        n_val;

    // y = x * log2e, Q16
    assign y_full = i_arg * $signed({1'b0, vgc_pkg::LOG2E_Q30});
    // z = frac * ln2, Q30
    assign z_full = 60'({r_y[15:0], 14'd0}) * 60'(vgc_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y    <= 24'(y_full >>> 30);
            r_t[0] <= 31'h4000_0000;
            r_s[0] <= 32'h4000_0000;
            r_z[0] <= z_full[59:30];
            r_n[0] <= r_y[23:16];
        end
    end

    // Taylor terms: multiply stage, then divide-by-k stage
    for (genvar k = 1; k <= 8; k++) begin : g_term
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / k);
        logic [60:0] mp;
        logic [63:0] rp;
        logic [30:0] q0;
        logic [34:0] kq;
        logic [34:0] rem;
        logic [30:0] q;

        assign mp  = 61'(r_t[2*k-2]) * 61'(r_z[2*k-2]);
        assign rp  = 64'(r_t[2*k-1]) * 64'(RECIP);
        assign q0  = rp[62:32];
        assign kq  = 35'(q0) * 35'(k);
        assign rem = 35'(r_t[2*k-1]) - kq;
        assign q   = (rem >= 35'(k)) ? q0 + 31'd1 : q0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[2*k-1] <= mp[60:30];
                r_s[2*k-1] <= r_s[2*k-2];
                r_z[2*k-1] <= r_z[2*k-2];
                r_n[2*k-1] <= r_n[2*k-2];
                r_t[2*k]   <= q;
                r_s[2*k]   <= r_s[2*k-1] + 32'(q);
                r_z[2*k]   <= r_z[2*k-1];
                r_n[2*k]   <= r_n[2*k-1];
            end
        end
    end

    // scale by 2^(n-14), saturating
    always_comb begin
        sh    = {r_n[NT-1][7], r_n[NT-1]} - 9'sd14;
        nsh   = 9'(-sh);
        wide  = 64'(r_s[NT-1]) << sh[5:0];
        n_val = r_s[NT-1] >> nsh;
        if (sh >= 0) begin
            if (sh > 9'sd32 || wide[63:32] != 32'd0) begin
                n_val = 32'hFFFF_FFFF;
            end else begin
                n_val = wide[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

>>> hw/rtl/vgc_div.sv
// ============================================================================
// vgc_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module vgc_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    for (genvar j = 0; j < NUM_W; j++) begin : g_stg
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign num_in = r_num[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        // shift in one numerator bit, subtract when it fits
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num[j] <= num_in << 1;
                r_den[j] <= den_in;
                r_quo[j] <= {quo_in[NUM_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

>>> hw/rtl/voltage_gated_channel_update_core.sv
// ============================================================================
// voltage_gated_channel_update_core
// Per-channel gating-variable Euler step with a channel table and current out.
// ============================================================================
// Usage:
//  - i_in carries items. Mode load writes the channel table entry (no result);
//    mode update steps the channel's gate with the given membrane voltage
//    and sends one result beat on o_out. Items with an index beyond the
//    table are taken and dropped.
//  - i_cfg_we/i_cfg_wdata write the time step dt; write it only when idle.
//  - Throughput: one item per cycle while o_out is not stalled. An item whose
//    channel matches an item still in the pipeline waits until that one has
//    written its gate back; only this check and o_out stalls limit the rate.
//  - Path: the result passes through the 19-stage exp units and the 63-stage
//    restoring dividers.
//  - Reset clears all valid bits and sets dt to 6554; the table is undefined
//    until loaded. No beat is taken while reset is held.
//  - When o_out stalls the whole pipeline holds; nothing is lost or repeated.
// ============================================================================
module voltage_gated_channel_update_core #(
    parameter int CHANNELS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    vgc_in_if.sink      i_in,
    vgc_out_if.source   o_out
);

    localparam int DEPTH = (CHANNELS < 1024) ? CHANNELS : 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NSTG  = vgc_pkg::NSTG;
    localparam logic signed [47:0] ARG_LIM = 48'(vgc_pkg::EXP_LIMIT) <<< vgc_pkg::FRAC_BITS;
    localparam logic [36:0] RMAX = 37'd1 << (vgc_pkg::FRAC_BITS + 20);

    // ---- control ----
    logic               en;
    logic               hazard;
    logic               in_ok;
    logic               accept;
    logic [AW-1:0]      in_addr;
    logic [30:0]        r_time_step;
    logic               r_vld  [NSTG];
    vgc_pkg::t_side     r_side [NSTG];
    vgc_pkg::t_side     n_side0;
    vgc_pkg::t_side     n_side1;

    // ---- memories ----
    vgc_pkg::t_prm      r_prm_mem  [DEPTH];
    logic [16:0]        r_gate_mem [DEPTH];
    vgc_pkg::t_prm      r_prm_rd;
    logic [16:0]        r_gate_rd;

    // ---- datapath ----
    logic signed [32:0] dv_full;
    logic signed [31:0] r_dv;
    logic signed [31:0] r_sc_o, r_sc_c, r_sc_s;
    logic signed [63:0] r_pr_o, r_pr_c, r_pr_s;
    logic signed [22:0] r_arg_o, r_arg_c, r_arg_s;
    logic [31:0]        w_alpha, w_beta, w_expn;
    logic [32:0]        ab_sum;
    logic [31:0]        r_rsum;
    logic [32:0]        r_den;
    logic [62:0]        r_num;
    logic [32:0]        r_den24;
    logic [62:0]        w_qr, w_qm;
    logic [36:0]        r_r;
    logic signed [17:0] r_diff;
    logic signed [55:0] r_dp;
    logic signed [39:0] m_full;
    logic [16:0]        n_m;
    logic [16:0]        r_m90, r_m91, r_m92;
    logic [47:0]        gm_full;
    logic [31:0]        r_gm;
    logic signed [32:0] r_drv;
    logic signed [65:0] r_pc;
    logic signed [49:0] cur_full;
    logic signed [31:0] n_cur;
    logic               r_out_vld;
    vgc_pkg::t_out_beat r_out;

    // exponent argument: floor(p / 2^F) clamped to the exp range
    function automatic logic signed [22:0] exp_arg(input logic signed [63:0] p);
        logic signed [47:0] s;
        logic signed [22:0] a;
        s = 48'(p >>> vgc_pkg::FRAC_BITS);
        if (s > ARG_LIM) begin
            a = 23'(ARG_LIM);
        end else if (s < -ARG_LIM) begin
            a = 23'(-ARG_LIM);
        end else begin
            a = s[22:0];
        end
        return a;
    endfunction

    // global advance: output register empty or being taken
    assign en = !r_out_vld || o_out.ready;

    // stall an item whose channel is still in flight
    always_comb begin
        hazard = 1'b0;
        for (int i = 0; i < NSTG; i++) begin
            if (r_vld[i] && r_side[i].ch == i_in.data.channel) begin
                hazard = 1'b1;
            end
        end
    end

    assign i_in.ready = i_rst_n && en && !hazard;
    assign accept     = i_in.valid && i_in.ready;
    assign in_ok      = 32'(i_in.data.channel) < 32'(CHANNELS);
    assign in_addr    = AW'(i_in.data.channel);

    // dt register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= 31'd6554;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_wdata;
        end
    end

    // channel table: written by loads at accept, read for every beat
    always_ff @(posedge i_clk) begin
        if (accept && in_ok && i_in.data.mode == vgc_pkg::MODE_LOAD) begin
            r_prm_mem[in_addr] <= '{
                neuron:    i_in.data.neuron_id,
                half:      i_in.data.half_voltage,
                sc_open:   i_in.data.opening_scale,
                sc_close:  i_in.data.closing_scale,
                sc_steady: i_in.data.steady_scale,
                tau:       i_in.data.tau_factor,
                cond:      i_in.data.max_conductance,
                erev:      i_in.data.reversal_voltage
            };
        end
        if (en) begin
            r_prm_rd <= r_prm_mem[in_addr];
        end
    end

    // gate table: written back at the last stage in item order
    always_ff @(posedge i_clk) begin
        if (en && r_vld[vgc_pkg::S_PC]) begin
            r_gate_mem[AW'(r_side[vgc_pkg::S_PC].ch)] <=
                (r_side[vgc_pkg::S_PC].mode == vgc_pkg::MODE_UPDATE) ?
                r_m92 : r_side[vgc_pkg::S_PC].gate;
        end
        if (en) begin
            r_gate_rd <= r_gate_mem[in_addr];
        end
    end

    // side data entering the pipe, then merged with table reads
    always_comb begin
        n_side0 = '{
            mode:   i_in.data.mode,
            ch:     i_in.data.channel,
            neuron: i_in.data.neuron_id,
            v:      i_in.data.membrane_v,
            gate:   (i_in.data.gate_initial > 17'd65536) ? 17'd65536 : i_in.data.gate_initial,
            tau:    i_in.data.tau_factor,
            cond:   i_in.data.max_conductance,
            erev:   i_in.data.reversal_voltage
        };
        n_side1 = r_side[0];
        if (r_side[0].mode == vgc_pkg::MODE_UPDATE) begin
            n_side1.neuron = r_prm_rd.neuron;
            n_side1.gate   = r_gate_rd;
            n_side1.tau    = r_prm_rd.tau;
            n_side1.cond   = r_prm_rd.cond;
            n_side1.erev   = r_prm_rd.erev;
        end
    end

    // valid bits travel with the side data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= accept && in_ok;
            for (int i = 1; i < NSTG; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            r_side[1] <= n_side1;
            for (int i = 2; i < NSTG; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // front end: dv, scale products, exponent arguments
    assign dv_full = {r_side[0].v[31], r_side[0].v} - {r_prm_rd.half[31], r_prm_rd.half};

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (dv_full > 33'sh0_7FFF_FFFF) begin
                r_dv <= 32'sh7FFF_FFFF;
            end else if (dv_full < -33'sh0_8000_0000) begin
                r_dv <= -32'sh8000_0000;
            end else begin
                r_dv <= dv_full[31:0];
            end
            r_sc_o  <= r_prm_rd.sc_open;
            r_sc_c  <= r_prm_rd.sc_close;
            r_sc_s  <= r_prm_rd.sc_steady;
            r_pr_o  <= r_dv * r_sc_o;
            r_pr_c  <= r_dv * r_sc_c;
            r_pr_s  <= r_dv * r_sc_s;
            r_arg_o <= exp_arg(r_pr_o);
            r_arg_c <= exp_arg(r_pr_c);
            r_arg_s <= -exp_arg(r_pr_s);
        end
    end

    // opening rate, closing rate and sigmoid exponential
    vgc_exp u_exp_open (.i_clk(i_clk), .i_en(en), .i_arg(r_arg_o), .o_val(w_alpha));
    vgc_exp u_exp_close (.i_clk(i_clk), .i_en(en), .i_arg(r_arg_c), .o_val(w_beta));
    vgc_exp u_exp_steady (.i_clk(i_clk), .i_en(en), .i_arg(r_arg_s), .o_val(w_expn));

    // rate sum, dt product and sigmoid denominator
    assign ab_sum = 33'(w_alpha) + 33'(w_beta);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsum  <= ab_sum[32] ? 32'hFFFF_FFFF : ab_sum[31:0];
            r_den   <= 33'(w_expn) + (33'd1 << vgc_pkg::FRAC_BITS);
            r_num   <= 63'(r_time_step) * 63'(r_rsum);
            r_den24 <= r_den;
        end
    end

    // rate = dt*(alpha+beta)/tau and steady state = 2^(16+F)/(2^F+e)
    vgc_div #(.NUM_W(vgc_pkg::DIV_NUM_W), .DEN_W(vgc_pkg::DIV_DEN_W)) u_div_rate (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num),
        .i_den (33'(r_side[vgc_pkg::S_PROD].tau)),
        .o_quo (w_qr)
    );

    vgc_div #(.NUM_W(vgc_pkg::DIV_NUM_W), .DEN_W(vgc_pkg::DIV_DEN_W)) u_div_minf (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (63'd1 << (16 + vgc_pkg::FRAC_BITS)),
        .i_den (r_den24),
        .o_quo (w_qm)
    );

    // Euler step and clamp
    always_comb begin
        m_full = 40'(r_dp >>> vgc_pkg::FRAC_BITS)
               + $signed({23'd0, r_side[vgc_pkg::S_DP].gate});
        if (m_full < 0) begin
            n_m = 17'd0;
        end else if (m_full > 40'sd65536) begin
            n_m = 17'd65536;
        end else begin
            n_m = m_full[16:0];
        end
    end

    // current: g*m, times driving force, saturated
    assign gm_full  = 48'(r_side[vgc_pkg::S_M].cond) * 48'(r_m90);
    assign cur_full = 50'(r_pc >>> vgc_pkg::FRAC_BITS);

    always_comb begin
        if (cur_full > 50'sh7FFF_FFFF) begin
            n_cur = 32'sh7FFF_FFFF;
        end else if (cur_full < -50'sh8000_0000) begin
            n_cur = -32'sh8000_0000;
        end else begin
            n_cur = cur_full[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_side[vgc_pkg::S_DIV_OUT].tau == 31'd0 || w_qr > 63'(RMAX)) begin
                r_r <= RMAX;
            end else begin
                r_r <= w_qr[36:0];
            end
            r_diff <= $signed({1'b0, w_qm[16:0]})
                    - $signed({1'b0, r_side[vgc_pkg::S_DIV_OUT].gate});
            r_dp   <= r_diff * $signed({1'b0, r_r});
            r_m90  <= n_m;
            r_gm   <= gm_full[47:16];
            r_drv  <= {r_side[vgc_pkg::S_M].erev[31], r_side[vgc_pkg::S_M].erev}
                    - {r_side[vgc_pkg::S_M].v[31], r_side[vgc_pkg::S_M].v};
            r_m91  <= r_m90;
            r_pc   <= $signed({1'b0, r_gm}) * r_drv;
            r_m92  <= r_m91;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[vgc_pkg::S_PC]
                      && r_side[vgc_pkg::S_PC].mode == vgc_pkg::MODE_UPDATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.channel_out <= r_side[vgc_pkg::S_PC].ch;
            r_out.neuron_out  <= r_side[vgc_pkg::S_PC].neuron;
            r_out.gate_value  <= r_m92;
            r_out.current_out <= n_cur;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule
